@@ rtl/core/rot_pkg.sv @@
// Shared types, constants and a helper function for the radar object age tracker.
package rot_pkg;

  localparam int SENSORS_DEF     = 5;
  localparam int MAX_OBJECTS_DEF = 64;

  localparam int SENSOR_W = 3;
  localparam int STAMP_W  = 32;
  localparam int ID_W     = 8;
  localparam int KIN_W    = 16;
  localparam int GATE_W   = 16;
  localparam int AGE_W    = 8;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 4;

  localparam logic [AGE_W-1:0] AGE_ONE = 8'd1;
  localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

  localparam logic [GATE_W-1:0] STAMP_GATE_RST    = 16'd500;
  localparam logic [GATE_W-1:0] VELOCITY_GATE_RST = 16'd1024;
  localparam logic [GATE_W-1:0] POSITION_GATE_RST = 16'd640;

  typedef enum logic [1:0] {
    REG_STAMP_GATE    = 2'd0,
    REG_VELOCITY_GATE = 2'd1,
    REG_POSITION_GATE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CARRIED    = 2'd0,
    ST_GATE_FAIL  = 2'd1,
    ST_NO_MATCH   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SEARCH,
    S_CHECK,
    S_WRITE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [GATE_W-1:0] stamp;
    logic [GATE_W-1:0] velocity;
    logic [GATE_W-1:0] position;
  } gates_t;

  typedef struct packed {
    logic signed [KIN_W-1:0] vel_y;
    logic signed [KIN_W-1:0] vel_x;
    logic signed [KIN_W-1:0] pos_y;
    logic signed [KIN_W-1:0] pos_x;
  } kin_t;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [ID_W-1:0]  id;
    kin_t             kin;
  } entry_t;

  function automatic logic within_gate(input logic signed [KIN_W-1:0] a,
                                       input logic signed [KIN_W-1:0] b,
                                       input logic [GATE_W-1:0] gate);
    logic [KIN_W:0] d;
    logic [KIN_W:0] m;
    d = {a[KIN_W-1], a} - {b[KIN_W-1], b};
    m = d[KIN_W] ? (~d + 1'b1) : d;
    return m < {1'b0, gate};
  endfunction

endpackage

@@ rtl/core/rot_in_if.sv @@
// Input item channel: one radar object slot per item.
interface rot_in_if import rot_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [SENSOR_W-1:0]        sensor;
  logic signed [STAMP_W-1:0]  frame_stamp;
  logic [ID_W-1:0]            obj_id;
  logic signed [KIN_W-1:0]    pos_x;
  logic signed [KIN_W-1:0]    pos_y;
  logic signed [KIN_W-1:0]    vel_x;
  logic signed [KIN_W-1:0]    vel_y;
  logic                       last_slot;

  modport source (
    output valid, sensor, frame_stamp, obj_id, pos_x, pos_y, vel_x, vel_y, last_slot,
    input  ready
  );
  modport sink (
    input  valid, sensor, frame_stamp, obj_id, pos_x, pos_y, vel_x, vel_y, last_slot,
    output ready
  );
endinterface

@@ rtl/core/rot_out_if.sv @@
// Result item channel: one object age report per item.
interface rot_out_if import rot_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] out_sensor;
  logic [ID_W-1:0]     out_id;
  logic [AGE_W-1:0]    age;
  logic [1:0]          status;
  logic                frame_end;

  modport source (
    output valid, out_sensor, out_id, age, status, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_sensor, out_id, age, status, frame_end,
    output ready
  );
endinterface

@@ rtl/core/rot_cfg.sv @@
// APB-style gate register block.
module rot_cfg import rot_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output gates_t             gates
);

  gates_t   gates_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign gates  = gates_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gates_r.stamp    <= STAMP_GATE_RST;
      gates_r.velocity <= VELOCITY_GATE_RST;
      gates_r.position <= POSITION_GATE_RST;
    end else if (wr) begin
      case (idx)
        REG_STAMP_GATE:    gates_r.stamp    <= pwdata[GATE_W-1:0];
        REG_VELOCITY_GATE: gates_r.velocity <= pwdata[GATE_W-1:0];
        REG_POSITION_GATE: gates_r.position <= pwdata[GATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STAMP_GATE:    prdata = PDATA_W'(gates_r.stamp);
      REG_VELOCITY_GATE: prdata = PDATA_W'(gates_r.velocity);
      REG_POSITION_GATE: prdata = PDATA_W'(gates_r.position);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/rot_obj_mem.sv @@
// Object table memory: one write port, one registered read port.
module rot_obj_mem import rot_pkg::*; #(
  parameter int DEPTH  = 2 * SENSORS_DEF * MAX_OBJECTS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/radar_object_age_tracker.sv @@
// Radar object age tracker: top level with frame control, id search and result register.
//
// in_if carries one object slot per item, grouped into frames by last_slot; out_if
// carries at most one age report per item. Gates are written over the APB-style port
// (stamp gate at 0x0, velocity gate at 0x4, position gate at 0x8).
// One item is worked at a time; in_if.ready is high only while the block waits for work.
// For each item, a dropped frame, an empty slot or an unknown sensor is done after setup,
// and a slot for a full table goes from setup straight to the result register. A stored
// object is searched for among the previous-frame entries when there are any, checked
// against the gates on an id match, written to the table and then put in the result
// register. The scan reads the object memory one entry per cycle.
// The result sits in an output register; the next item is taken while it waits.
// If out_if stalls with a result still held, the following object waits before
// its own report. Reset clears all frame state and gates; table contents are
// unknown until written, and only written entries are ever read.
module radar_object_age_tracker import rot_pkg::*; #(
  parameter int SENSORS     = SENSORS_DEF,
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  rot_in_if.sink             in_if,
  rot_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int BANKS  = 2 * SENSORS;
  localparam int SENS_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int BANK_W = $clog2(BANKS);
  localparam int SLOT_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
  localparam int DEPTH  = BANKS * MAX_OBJECTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] MAX_A = ADDR_W'(MAX_OBJECTS);
  localparam logic [CNT_W-1:0]  MAX_C = CNT_W'(MAX_OBJECTS);

  gates_t gates;

  rot_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gates   (gates)
  );

  state_t state_r, state_nxt;

  logic [SENSOR_W-1:0] it_sensor_r;
  logic [STAMP_W-1:0]  it_stamp_r;
  logic [ID_W-1:0]     it_id_r;
  kin_t                it_kin_r;
  logic                it_last_r;

  logic                in_frame_r;
  logic                dropping_r;
  logic [SENSORS-1:0]  bank_sel_r;
  logic [SENSORS-1:0]  has_prev_r;
  logic [CNT_W-1:0]    bank_cnt_r   [BANKS];
  logic [STAMP_W-1:0]  bank_stamp_r [BANKS];

  logic [BANK_W-1:0]   wb_r, pb_r;
  logic                stamp_ok_r;
  logic [CNT_W-1:0]    prev_cnt_r;
  logic [SLOT_W-1:0]   k_r;
  logic [AGE_W-1:0]    res_age_r;
  status_t             res_status_r;

  logic                out_valid_r;
  logic [SENSOR_W-1:0] out_sensor_r;
  logic [ID_W-1:0]     out_id_r;
  logic [AGE_W-1:0]    out_age_r;
  status_t             out_status_r;
  logic                out_end_r;

  logic [SENS_W-1:0]   sidx;
  logic                sens_ok;
  logic [BANK_W-1:0]   wb, pb;
  logic                start;
  logic                drop;
  logic [CNT_W-1:0]    cnt_w;
  logic [STAMP_W-1:0]  stamp_w;
  logic [STAMP_W:0]    ds;
  logic                stamp_ok;
  logic                obj_live;
  logic                table_full;
  logic                search_go;
  logic                hit;
  logic                k_last;
  logic                chk_ok;
  logic [AGE_W-1:0]    age_inc;
  logic                in_setup;
  logic                commit;
  logic                end_frame;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  entry_t              rd_data;
  logic                mem_we;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic                out_load;

  rot_obj_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sidx     = SENS_W'(it_sensor_r);
  assign sens_ok  = 32'(it_sensor_r) < SENSORS;
  assign wb       = BANK_W'({sidx, ~bank_sel_r[sidx]});
  assign pb       = BANK_W'({sidx, bank_sel_r[sidx]});
  assign start    = ~in_frame_r;
  assign drop     = start ? it_stamp_r[STAMP_W-1] : dropping_r;
  assign cnt_w    = start ? '0 : bank_cnt_r[wb];
  assign stamp_w  = start ? it_stamp_r : bank_stamp_r[wb];
  assign ds       = {stamp_w[STAMP_W-1], stamp_w} -
                    {bank_stamp_r[pb][STAMP_W-1], bank_stamp_r[pb]};
  assign stamp_ok = $signed(ds) < $signed((STAMP_W + 1)'(gates.stamp));

  assign in_setup   = state_r == S_SETUP;
  assign obj_live   = sens_ok && !drop && (it_id_r != '0);
  assign table_full = cnt_w >= MAX_C;
  assign search_go  = has_prev_r[sidx] && (bank_cnt_r[pb] != '0);

  assign hit    = rd_data.id == it_id_r;
  assign k_last = (CNT_W'(k_r) + CNT_W'(1)) == prev_cnt_r;

  assign chk_ok = stamp_ok_r &&
                  within_gate(it_kin_r.vel_x, rd_data.kin.vel_x, gates.velocity) &&
                  within_gate(it_kin_r.vel_y, rd_data.kin.vel_y, gates.velocity) &&
                  within_gate(it_kin_r.pos_x, rd_data.kin.pos_x, gates.position) &&
                  within_gate(it_kin_r.pos_y, rd_data.kin.pos_y, gates.position);
  assign age_inc = (rd_data.age == AGE_MAX) ? AGE_MAX : rd_data.age + AGE_ONE;

  assign wr_addr = ADDR_W'(wb_r) * MAX_A + ADDR_W'(bank_cnt_r[wb_r]);
  assign wr_data = '{age: res_age_r, id: it_id_r, kin: it_kin_r};

  assign commit    = (in_setup && sens_ok && !drop && (it_id_r == '0) && it_last_r) ||
                     (out_load && it_last_r);
  assign end_frame = commit || (in_setup && it_last_r && (!sens_ok || drop));

  assign in_if.ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (!obj_live) begin
          state_nxt = S_IDLE;
        end else if (table_full) begin
          state_nxt = S_FINISH;
        end else if (search_go) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(pb) * MAX_A;
          state_nxt = S_SEARCH;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_nxt = S_CHECK;
        end else if (k_last) begin
          state_nxt = S_WRITE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(pb_r) * MAX_A + ADDR_W'(k_r) + ADDR_W'(1);
        end
      end
      S_CHECK: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // item capture and per-item working registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      it_sensor_r <= in_if.sensor;
      it_stamp_r  <= in_if.frame_stamp;
      it_id_r     <= in_if.obj_id;
      it_kin_r    <= '{vel_y: in_if.vel_y, vel_x: in_if.vel_x,
                       pos_y: in_if.pos_y, pos_x: in_if.pos_x};
      it_last_r   <= in_if.last_slot;
    end
    if (in_setup) begin
      wb_r         <= wb;
      pb_r         <= pb;
      stamp_ok_r   <= stamp_ok;
      prev_cnt_r   <= bank_cnt_r[pb];
      k_r          <= '0;
      res_age_r    <= AGE_ONE;
      res_status_r <= table_full ? ST_TABLE_FULL : ST_NO_MATCH;
    end
    if (state_r == S_SEARCH && !hit && !k_last) begin
      k_r <= k_r + SLOT_W'(1);
    end
    if (state_r == S_CHECK) begin
      res_status_r <= chk_ok ? ST_CARRIED : ST_GATE_FAIL;
      res_age_r    <= chk_ok ? age_inc : AGE_ONE;
    end
    if (out_load) begin
      out_sensor_r <= it_sensor_r;
      out_id_r     <= it_id_r;
      out_age_r    <= res_age_r;
      out_status_r <= res_status_r;
      out_end_r    <= it_last_r;
    end
  end

  // frame and bank control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      dropping_r <= 1'b0;
      bank_sel_r <= '0;
      has_prev_r <= '0;
      for (int i = 0; i < BANKS; i++) begin
        bank_cnt_r[i]   <= '0;
        bank_stamp_r[i] <= '0;
      end
    end else begin
      if (in_setup && sens_ok && start) begin
        in_frame_r <= 1'b1;
        dropping_r <= it_stamp_r[STAMP_W-1];
        if (!it_stamp_r[STAMP_W-1]) begin
          bank_cnt_r[wb]   <= '0;
          bank_stamp_r[wb] <= it_stamp_r;
        end
      end
      if (mem_we) begin
        bank_cnt_r[wb_r] <= bank_cnt_r[wb_r] + CNT_W'(1);
      end
      if (commit) begin
        bank_sel_r[sidx] <= ~bank_sel_r[sidx];
        has_prev_r[sidx] <= 1'b1;
      end
      if (end_frame) begin
        in_frame_r <= 1'b0;
        dropping_r <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_sensor = out_sensor_r;
  assign out_if.out_id     = out_id_r;
  assign out_if.age        = out_age_r;
  assign out_if.status     = out_status_r;
  assign out_if.frame_end  = out_end_r;

endmodule

@@ tb/rot_age_checker.sv @@
// Checker for the radar object age tracker: predicts age reports and compares them.
`timescale 1ns / 1ps

module rot_age_checker import rot_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rot_in_if                  in_mon,
  rot_out_if                 out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 failures,
  output int                 reports_due
);

  localparam int NS = SENSORS_DEF;
  localparam int NO = MAX_OBJECTS_DEF;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [ID_W-1:0]     id;
    logic [AGE_W-1:0]    age;
    status_t             status;
    logic                frame_end;
  } report_t;

  entry_t             obj_tab [NS*2*NO];
  int                 bank_fill [NS*2];
  logic signed [31:0] bank_time [NS*2];
  bit                 bank_sel [NS];
  bit                 committed [NS];
  bit                 frame_open;
  bit                 frame_drop;
  gates_t             gates;
  report_t            due_reports [$];
  int                 errors = 0;

  assign failures = errors;

  function automatic bit near(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic [15:0] g);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d < int'(g);
  endfunction

  function automatic bit age_slot(input logic [SENSOR_W-1:0] sensor,
                                  input logic signed [31:0] stamp,
                                  input logic [ID_W-1:0] id, input kin_t kin,
                                  input logic last, output report_t rep);
    int         wb;
    int         pb;
    int         e;
    bit         found;
    longint     gap;
    logic [7:0] age;
    status_t    st;
    rep = '0;
    if (int'(sensor) >= NS) begin
      if (last) begin
        frame_open = 1'b0;
        frame_drop = 1'b0;
      end
      return 1'b0;
    end
    wb = int'(sensor) * 2 + int'(bank_sel[sensor] ^ 1'b1);
    pb = int'(sensor) * 2 + int'(bank_sel[sensor]);
    if (!frame_open) begin
      frame_open = 1'b1;
      frame_drop = stamp[31];
      if (!frame_drop) begin
        bank_fill[wb] = 0;
        bank_time[wb] = stamp;
      end
    end
    if (frame_drop) begin
      if (last) begin
        frame_open = 1'b0;
        frame_drop = 1'b0;
      end
      return 1'b0;
    end
    if (id != '0) begin
      age = AGE_ONE;
      if (bank_fill[wb] >= NO) begin
        st = ST_TABLE_FULL;
      end else begin
        st = ST_NO_MATCH;
        found = 1'b0;
        if (committed[sensor]) begin
          for (int k = 0; k < NO; k++) begin
            e = pb * NO + k;
            if (!found && k < bank_fill[pb] && obj_tab[e].id == id) begin
              found = 1'b1;
              gap = longint'(bank_time[wb]) - longint'(bank_time[pb]);
              if (gap < longint'(gates.stamp) &&
                  near(kin.vel_x, obj_tab[e].kin.vel_x, gates.velocity) &&
                  near(kin.vel_y, obj_tab[e].kin.vel_y, gates.velocity) &&
                  near(kin.pos_x, obj_tab[e].kin.pos_x, gates.position) &&
                  near(kin.pos_y, obj_tab[e].kin.pos_y, gates.position)) begin
                st = ST_CARRIED;
                age = (obj_tab[e].age < AGE_MAX) ? obj_tab[e].age + 8'd1 : AGE_MAX;
              end else begin
                st = ST_GATE_FAIL;
              end
            end
          end
        end
        obj_tab[wb * NO + bank_fill[wb]] = '{age: age, id: id, kin: kin};
        bank_fill[wb]++;
      end
      rep = '{sensor: sensor, id: id, age: age, status: st, frame_end: last};
    end
    if (last) begin
      bank_sel[sensor] = ~bank_sel[sensor];
      committed[sensor] = 1'b1;
      frame_open = 1'b0;
      frame_drop = 1'b0;
    end
    return id != '0;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    report_t rep;
    kin_t    kin;
    if (!rst_n) begin
      gates = '{stamp: STAMP_GATE_RST, velocity: VELOCITY_GATE_RST,
                position: POSITION_GATE_RST};
      for (int b = 0; b < NS*2; b++) begin
        bank_fill[b] = 0;
        bank_time[b] = '0;
      end
      for (int s = 0; s < NS; s++) begin
        bank_sel[s] = 1'b0;
        committed[s] = 1'b0;
      end
      frame_open = 1'b0;
      frame_drop = 1'b0;
      due_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_STAMP_GATE:    gates.stamp = pwdata[15:0];
          REG_VELOCITY_GATE: gates.velocity = pwdata[15:0];
          REG_POSITION_GATE: gates.position = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{sensor: out_mon.out_sensor, id: out_mon.out_id, age: out_mon.age,
                status: status_t'(out_mon.status), frame_end: out_mon.frame_end};
        if (due_reports.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected item: sensor %0d id %0d age %0d status %0d end %0d",
                     $time, got.sensor, got.id, got.age, got.status, got.frame_end);
          errors++;
        end else begin
          want = due_reports.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display({"%0t: mismatch: expected sensor %0d id %0d age %0d status %0d ",
                        "end %0d, got sensor %0d id %0d age %0d status %0d end %0d"},
                       $time, want.sensor, want.id, want.age, want.status, want.frame_end,
                       got.sensor, got.id, got.age, got.status, got.frame_end);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        kin = '{vel_y: in_mon.vel_y, vel_x: in_mon.vel_x, pos_y: in_mon.pos_y,
                pos_x: in_mon.pos_x};
        if (age_slot(in_mon.sensor, in_mon.frame_stamp, in_mon.obj_id, kin,
                     in_mon.last_slot, rep))
          due_reports.push_back(rep);
      end
    end
    reports_due <= due_reports.size();
  end

endmodule

@@ tb/tb_radar_object_age_tracker.sv @@
// Testbench top for the radar object age tracker: stimulus, gate setup and verdict.
`timescale 1ns / 1ps

module tb_radar_object_age_tracker;
  import rot_pkg::*;

  localparam int NS     = SENSORS_DEF;
  localparam int NO     = MAX_OBJECTS_DEF;
  localparam int SETTLE = MAX_OBJECTS_DEF + 16;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               rx_ready = 1'b0;
  int                 failures;
  int                 reports_due;
  int                 send_idle = 0;
  int                 recv_stall = 0;
  int                 sent_items = 0;
  logic [15:0]        g_stamp = STAMP_GATE_RST;
  logic [15:0]        g_vel = VELOCITY_GATE_RST;
  logic [15:0]        g_pos = POSITION_GATE_RST;
  logic [7:0]         trk_id [NS][NO];
  kin_t               trk_kin [NS][NO];
  int                 trk_n [NS];
  logic signed [31:0] trk_time [NS];

  rot_in_if  in_ch ();
  rot_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  radar_object_age_tracker u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rot_age_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (failures),
    .reports_due (reports_due)
  );

  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_slot(input logic [2:0] sensor, input logic signed [31:0] stamp,
                           input logic [7:0] id, input kin_t kin, input logic last);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sensor      <= sensor;
    in_ch.frame_stamp <= stamp;
    in_ch.obj_id      <= id;
    in_ch.pos_x       <= kin.pos_x;
    in_ch.pos_y       <= kin.pos_y;
    in_ch.vel_x       <= kin.vel_x;
    in_ch.vel_y       <= kin.vel_y;
    in_ch.last_slot   <= last;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // hold off until every report is in, then let any silent item finish
  task automatic settle();
    int n;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (n = 0; reports_due != 0 && n < 200000; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_gates(input logic [15:0] s, input logic [15:0] v, input logic [15:0] p);
    cfg_write(REG_STAMP_GATE, s);
    cfg_write(REG_VELOCITY_GATE, v);
    cfg_write(REG_POSITION_GATE, p);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    g_stamp = s;
    g_vel   = v;
    g_pos   = p;
  endtask

  function automatic logic [15:0] jitter(input logic [15:0] v, input logic [15:0] g);
    int span;
    span = int'(g) + int'(g) / 4 + 1;
    if (span > 30000) span = 30000;
    return v + 16'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic kin_t nudge(input kin_t k);
    kin_t r;
    r.pos_x = jitter(k.pos_x, g_pos);
    r.pos_y = jitter(k.pos_y, g_pos);
    r.vel_x = jitter(k.vel_x, g_vel);
    r.vel_y = jitter(k.vel_y, g_vel);
    return r;
  endfunction

  task automatic random_frame();
    int                 s;
    int                 n;
    int                 pick;
    int                 j;
    int                 new_n;
    logic [2:0]         slot_s;
    logic signed [31:0] stamp;
    logic [7:0]         id;
    kin_t               kin;
    logic [7:0]         new_id [NO];
    kin_t               new_kin [NO];
    s = $urandom_range(NS - 1);
    n = ($urandom_range(99) < 3) ? NO + $urandom_range(1, 4) : $urandom_range(1, 12);
    pick = $urandom_range(99);
    if (pick < 8)
      stamp = $urandom;
    else
      stamp = trk_time[s] + 32'($urandom_range(0, int'(g_stamp) + int'(g_stamp) / 4 + 1));
    new_n = 0;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      kin = {$urandom, $urandom};
      if (trk_n[s] > 0 && pick < 65) begin
        j = $urandom_range(trk_n[s] - 1);
        id = trk_id[s][j];
        kin = nudge(trk_kin[s][j]);
      end else if (pick < 88) begin
        id = 8'($urandom);
      end else begin
        id = '0;
      end
      if ($urandom_range(99) < 4)
        push_slot(3'($urandom_range(NS, 7)), $urandom, 8'($urandom), {$urandom, $urandom},
                  $urandom_range(9) == 0);
      slot_s = ($urandom_range(99) < 3) ? 3'($urandom_range(NS - 1)) : 3'(s);
      push_slot(slot_s, (k == 0) ? stamp : 32'($urandom), id, kin, k == n - 1);
      if (id != '0 && new_n < NO && slot_s == 3'(s)) begin
        new_id[new_n]  = id;
        new_kin[new_n] = kin;
        new_n++;
      end
    end
    if (!stamp[31]) begin
      trk_n[s]    = new_n;
      trk_time[s] = stamp;
      for (int k = 0; k < new_n; k++) begin
        trk_id[s][k]  = new_id[k];
        trk_kin[s][k] = new_kin[k];
      end
    end
  endtask

  // one object seen frame after frame, long enough to saturate its age
  task automatic age_track(input int frames);
    logic signed [31:0] stamp;
    kin_t               kin;
    stamp = 32'sd1000;
    kin = {$urandom, $urandom};
    for (int f = 0; f < frames; f++) begin
      stamp = stamp + 32'($urandom_range(1, 20));
      kin.pos_x = jitter(kin.pos_x, 16'd2);
      kin.pos_y = jitter(kin.pos_y, 16'd2);
      kin.vel_x = jitter(kin.vel_x, 16'd2);
      kin.vel_y = jitter(kin.vel_y, 16'd2);
      push_slot(3'd3, stamp, 8'd77, kin, 1'b1);
    end
    trk_n[3]      = 1;
    trk_id[3][0]  = 8'd77;
    trk_kin[3][0] = kin;
    trk_time[3]   = stamp;
  endtask

  task automatic run_until(input int target);
    while (sent_items < target) begin
      random_frame();
      if ($urandom_range(99) == 0) settle();
    end
  endtask

  initial begin
    kin_t k1;
    kin_t k2;
    kin_t kx;
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.sensor      <= '0;
    in_ch.frame_stamp <= '0;
    in_ch.obj_id      <= '0;
    in_ch.pos_x       <= '0;
    in_ch.pos_y       <= '0;
    in_ch.vel_x       <= '0;
    in_ch.vel_y       <= '0;
    in_ch.last_slot   <= 1'b0;
    for (int s = 0; s < NS; s++) begin
      trk_n[s]    = 0;
      trk_time[s] = '0;
    end
    k1 = '{vel_y: -16'sd400, vel_x: 16'sd300, pos_y: -16'sd200, pos_x: 16'sd100};
    k2 = '{vel_y: 16'sd50, vel_x: -16'sd60, pos_y: 16'sd70, pos_x: -16'sd80};
    kx = '{vel_y: -16'sd32768, vel_x: 16'sd32767, pos_y: -16'sd32768, pos_x: 16'sd32767};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // fresh objects, then carry, gate miss, new id and a silent commit
    push_slot(3'd0, 32'sd0, 8'd1, k1, 1'b0);
    push_slot(3'd0, 32'sd0, 8'd2, k2, 1'b1);
    push_slot(3'd0, 32'sd100, 8'd1, k1, 1'b0);
    k2.pos_x = k2.pos_x + 16'sd640;
    push_slot(3'd0, 32'sd100, 8'd2, k2, 1'b0);
    push_slot(3'd0, 32'sd100, 8'd3, k2, 1'b0);
    push_slot(3'd0, 32'sd100, 8'd0, k2, 1'b1);
    // stamp gap equal to the gate
    push_slot(3'd0, 32'sd600, 8'd1, k1, 1'b1);
    // dropped frame, then unknown sensors
    push_slot(3'd1, 32'sh8000_0000, 8'd9, k1, 1'b0);
    push_slot(3'd1, 32'sd5, 8'd10, k1, 1'b1);
    push_slot(3'd7, 32'sd0, 8'd5, k1, 1'b0);
    push_slot(3'd5, 32'sd0, 8'd6, k1, 1'b1);
    // field extremes and a wrapped stamp gap
    push_slot(3'd4, 32'sh7fff_ffff, 8'd255, kx, 1'b1);
    push_slot(3'd4, 32'sd0, 8'd255, kx, 1'b1);
    kx.pos_x = -16'sd32768;
    push_slot(3'd4, 32'sd1, 8'd255, kx, 1'b1);
    // sensor change inside a frame
    push_slot(3'd2, 32'sd50, 8'd20, k1, 1'b0);
    push_slot(3'd3, 32'sd50, 8'd21, k1, 1'b1);
    push_slot(3'd2, 32'sd60, 8'd20, k1, 1'b1);
    // velocity just inside the gate
    k1.vel_x = k1.vel_x + 16'sd1023;
    push_slot(3'd0, 32'sd700, 8'd1, k1, 1'b1);

    age_track(260);
    run_until(380);
    settle();

    set_gates(16'($urandom_range(0, 1200)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 1500)));
    send_idle = 74;
    run_until(760);
    settle();

    set_gates(16'hffff, 16'hffff, 16'hffff);
    send_idle = 0;
    recv_stall = 74;
    run_until(1140);
    settle();

    set_gates(16'h0000, 16'h0000, 16'h0000);
    send_idle = 28;
    recv_stall = 28;
    run_until(1520);
    settle();

    set_gates(16'($urandom_range(50, 2000)), 16'($urandom), 16'($urandom_range(1, 3000)));
    send_idle = 0;
    recv_stall = 0;
    run_until(1900);
    settle();

    if (failures == 0 && reports_due == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
